@@ design/stack_vm_instruction_executor_assert.svh @@
// Assertion macros shared by the stack machine executor RTL.
// Depends on nothing; each user supplies the clock name, and for SVM_ASSERT the reset name, in the macro call.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SVM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/svm_pkg.sv @@
// Package for the stack machine executor: opcodes, status codes and control structs.
// Depends on nothing.
`default_nettype none
package svm_pkg;

   localparam int NUM_REGS = 8;
   localparam logic [15:0] OPCODE_COUNT = 16'd22;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_PAST    = 3'd2;
   localparam logic [2:0] ST_DATA    = 3'd3;
   localparam logic [2:0] ST_STACK   = 3'd4;
   localparam logic [2:0] ST_MOD0    = 3'd5;
   localparam logic [2:0] ST_BADADDR = 3'd6;

   localparam logic [4:0] OP_HALT = 5'd0;
   localparam logic [4:0] OP_SET  = 5'd1;
   localparam logic [4:0] OP_PUSH = 5'd2;
   localparam logic [4:0] OP_POP  = 5'd3;
   localparam logic [4:0] OP_EQ   = 5'd4;
   localparam logic [4:0] OP_GT   = 5'd5;
   localparam logic [4:0] OP_JMP  = 5'd6;
   localparam logic [4:0] OP_JT   = 5'd7;
   localparam logic [4:0] OP_JF   = 5'd8;
   localparam logic [4:0] OP_ADD  = 5'd9;
   localparam logic [4:0] OP_MULT = 5'd10;
   localparam logic [4:0] OP_MOD  = 5'd11;
   localparam logic [4:0] OP_AND  = 5'd12;
   localparam logic [4:0] OP_OR   = 5'd13;
   localparam logic [4:0] OP_NOT  = 5'd14;
   localparam logic [4:0] OP_RMEM = 5'd15;
   localparam logic [4:0] OP_WMEM = 5'd16;
   localparam logic [4:0] OP_CALL = 5'd17;
   localparam logic [4:0] OP_RET  = 5'd18;
   localparam logic [4:0] OP_OUT  = 5'd19;
   localparam logic [4:0] OP_IN   = 5'd20;
   localparam logic [4:0] OP_NOP  = 5'd21;

   typedef struct packed {
      logic       start;
      logic [4:0] op;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic zero_div;
   } alu_stat_type;

   // Number of operand words that follow each opcode.
   function automatic logic [1:0] opnd_count(input logic [4:0] op);
      logic [1:0] n;
      unique case (op)
         OP_HALT, OP_RET, OP_NOP: n = 2'd0;
         OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN: n = 2'd1;
         OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM: n = 2'd2;
         default: n = 2'd3;
      endcase
      return n;
   endfunction

   // True when the first operand names the destination register.
   function automatic logic has_dst(input logic [4:0] op);
      logic d;
      unique case (op)
         OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND,
         OP_OR, OP_NOT, OP_RMEM, OP_IN: d = 1'b1;
         default: d = 1'b0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

@@ design/svm_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing.
`default_nettype none
interface svm_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [14:0] load_addr;
   logic [15:0] load_data;
   logic [7:0]  in_char;
   modport source(output valid, req_type, load_addr, load_data, in_char, input ready);
   modport sink(input valid, req_type, load_addr, load_data, in_char, output ready);
endinterface

interface svm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] pc_after;
   logic [15:0] opcode_seen;
   logic        out_valid;
   logic [7:0]  out_char;
   logic        in_used;
   modport source(output valid, status, pc_after, opcode_seen, out_valid, out_char, in_used,
                  input ready);
   modport sink(input valid, status, pc_after, opcode_seen, out_valid, out_char, in_used,
                output ready);
endinterface
`default_nettype wire

@@ design/svm_ram.sv @@
// Generic RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none
module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ design/svm_alu.sv @@
// Shared arithmetic unit: combinational compare, add, multiply and logic, iterative remainder.
// Depends on svm_pkg.
`default_nettype none
module svm_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  svm_pkg::alu_req_type alu_req,
   input  logic [15:0]          opa,
   input  logic [15:0]          opb,
   output logic [15:0]          result,
   output svm_pkg::alu_stat_type alu_stat
);
   import svm_pkg::*;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;
   logic [16:0] sum;
   logic [31:0] prod;

   // Restoring remainder, one dividend bit per cycle.
   always_comb begin
      trial  = {rem_ff, dvd_ff[15]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (alu_req.start && alu_req.op == OP_MOD) begin
         busy_in = 1'b1;
         cnt_in  = 5'd16;
         rem_in  = '0;
         dvd_in  = opa;
         dvs_in  = opb;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[15:0];
         end
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      sum  = {1'b0, opa} + {1'b0, opb};
      prod = opa * opb;
      unique case (alu_req.op)
         OP_EQ:   result = {15'b0, opa == opb};
         OP_GT:   result = {15'b0, opa > opb};
         OP_ADD:  result = {1'b0, sum[14:0]};
         OP_MULT: result = {1'b0, prod[14:0]};
         OP_MOD:  result = {1'b0, rem_ff[14:0]};
         OP_AND:  result = opa & opb;
         OP_OR:   result = opa | opb;
         OP_NOT:  result = {1'b0, ~opa[14:0]};
         default: result = '0;
      endcase
   end

   assign alu_stat.busy     = busy_ff;
   assign alu_stat.zero_div = (opb == 16'd0);
endmodule
`default_nettype wire

@@ design/stack_vm_instruction_executor.sv @@
// Sequence from accepting a request to raising the response valid: a load, or a step that
// fetches nothing, goes straight to S_DONE; a data word passes S_OPW; an instruction passes
// S_OPW, S_OPND and S_OPNDW per operand word, then S_EXEC, every word going through the one
// memory port; a modulo adds S_MOD for the shared unit and a stack or memory read-back adds
// S_STKW or S_MEMW. Throughput: one transaction at a time; the next is taken once the previous
// has moved to the output register. Reset: synchronous, active high; then memory is cleared.
`default_nettype none
module stack_vm_instruction_executor #(
   parameter int MEM_WORDS   = 32768,
   parameter int STACK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   svm_req_if.sink     req_chan,
   svm_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import svm_pkg::*;
   `include "stack_vm_instruction_executor_assert.svh"

   localparam int AW = $clog2(MEM_WORDS);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);
   localparam logic [PW-1:0] SP_FULL = PW'(STACK_DEPTH);

   // The sequencer walks each instruction through fetch, operand fetch, execute and,
   // where needed, a wait for the shared unit or a RAM read-back.
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_OPW, S_OPND, S_OPNDW, S_EXEC, S_MOD, S_MEMW, S_STKW, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] npc_ff, npc_in;
   logic        halted_ff, halted_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [15:0] img_ff, img_in;
   logic [15:0] regs_ff [NUM_REGS];
   logic [4:0]  op_ff, op_in;
   logic [1:0]  n_ff, n_in;
   logic [1:0]  k_ff, k_in;
   logic [15:0] wrd_ff [3];
   logic [15:0] wrd_in [3];
   logic [15:0] val_ff [3];
   logic [15:0] val_in [3];
   logic        bad_ff, bad_in;
   logic [2:0]  st_ff, st_in;
   logic [15:0] seen_ff, seen_in;
   logic        ov_ff, ov_in;
   logic [7:0]  oc_ff, oc_in;
   logic        iu_ff, iu_in;
   logic [7:0]  inchr_ff, inchr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_pc_ff, rsp_pc_in;
   logic [15:0] rsp_seen_ff, rsp_seen_in;
   logic        rsp_ov_ff, rsp_ov_in;
   logic [7:0]  rsp_oc_ff, rsp_oc_in;
   logic        rsp_iu_ff, rsp_iu_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata, mem_rdata;
   logic          stk_we;
   logic [SW-1:0] stk_waddr, stk_raddr;
   logic [15:0]   stk_wdata, stk_rdata;

   logic          reg_we;
   logic [2:0]    reg_wsel;
   logic [15:0]   reg_wdata;

   alu_req_type   alu_req;
   alu_stat_type  alu_stat;
   logic [15:0]   alu_result;

   logic [16:0]   fetch_addr;
   logic [PW-1:0] sp_dec;
   logic          word_is_reg;
   logic          word_bad;
   logic          accept;

   svm_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_main_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   svm_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack_mem (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   // The arithmetic unit always sees the second and third operand values.
   svm_alu u_alu (
      .clock(clock), .reset(reset), .alu_req(alu_req), .opa(val_ff[1]), .opb(val_ff[2]),
      .result(alu_result), .alu_stat(alu_stat)
   );

   assign accept     = req_chan.valid && req_chan.ready;
   assign fetch_addr = {1'b0, pc_ff} + 17'd1 + {15'b0, k_ff};
   assign sp_dec     = sp_ff - PW'(1);
   // An operand word names a register only within the eight words from 32768 upward.
   assign word_is_reg = mem_rdata[15] && (mem_rdata[14:3] == 12'd0);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pc_in     = pc_ff;
      npc_in    = npc_ff;
      halted_in = halted_ff;
      sp_in     = sp_ff;
      img_in    = csr_we ? csr_wdata : img_ff;
      op_in     = op_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      wrd_in    = wrd_ff;
      val_in    = val_ff;
      bad_in    = bad_ff;
      st_in     = st_ff;
      seen_in   = seen_ff;
      ov_in     = ov_ff;
      oc_in     = oc_ff;
      iu_in     = iu_ff;
      inchr_in  = inchr_ff;
      word_bad  = bad_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_ov_in     = rsp_ov_ff;
      rsp_oc_in     = rsp_oc_ff;
      rsp_iu_in     = rsp_iu_ff;

      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;
      stk_we    = 1'b0;
      stk_waddr = sp_ff[SW-1:0];
      stk_wdata = '0;
      stk_raddr = sp_dec[SW-1:0];
      reg_we    = 1'b0;
      reg_wsel  = wrd_ff[0][2:0];
      reg_wdata = '0;
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               st_in    = ST_OK;
               seen_in  = '0;
               ov_in    = 1'b0;
               oc_in    = '0;
               iu_in    = 1'b0;
               npc_in   = pc_ff;
               inchr_in = req_chan.in_char;
               k_in     = '0;
               bad_in   = 1'b0;
               state_in = S_DONE;
               if (!req_chan.req_type) begin
                  if ({2'b0, req_chan.load_addr} < MEM_LIMIT) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(req_chan.load_addr);
                     mem_wdata = req_chan.load_data;
                  end
               end else if (halted_ff) begin
                  st_in = ST_HALT;
               end else if (pc_ff >= img_ff) begin
                  st_in = ST_PAST;
               end else if ({1'b0, pc_ff} >= MEM_LIMIT) begin
                  st_in = ST_BADADDR;
               end else begin
                  mem_raddr = pc_ff[AW-1:0];
                  state_in  = S_OPW;
               end
            end
         end
         S_OPW: begin
            seen_in = mem_rdata;
            op_in   = mem_rdata[4:0];
            n_in    = opnd_count(mem_rdata[4:0]);
            if (mem_rdata >= OPCODE_COUNT) begin
               // A data word is stepped over.
               st_in    = ST_DATA;
               npc_in   = pc_ff + 16'd1;
               state_in = S_DONE;
            end else if (opnd_count(mem_rdata[4:0]) == 2'd0) begin
               state_in = S_EXEC;
            end else begin
               state_in = S_OPND;
            end
         end
         S_OPND: begin
            if (fetch_addr >= MEM_LIMIT) begin
               st_in    = ST_BADADDR;
               state_in = S_DONE;
            end else begin
               mem_raddr = fetch_addr[AW-1:0];
               state_in  = S_OPNDW;
            end
         end
         S_OPNDW: begin
            wrd_in[k_ff] = mem_rdata;
            val_in[k_ff] = mem_rdata[15] ? regs_ff[mem_rdata[2:0]] : mem_rdata;
            if (k_ff == 2'd0 && has_dst(op_ff)) begin
               word_bad = bad_ff || !word_is_reg;
            end else begin
               word_bad = bad_ff || (mem_rdata[15] && !word_is_reg);
            end
            bad_in = word_bad;
            k_in   = k_ff + 2'd1;
            if (k_ff + 2'd1 == n_ff) begin
               if (word_bad) begin
                  st_in    = ST_BADADDR;
                  state_in = S_DONE;
               end else begin
                  state_in = S_EXEC;
               end
            end else begin
               state_in = S_OPND;
            end
         end
         S_EXEC: begin
            npc_in   = pc_ff + 16'd1 + {14'b0, n_ff};
            state_in = S_DONE;
            unique case (op_ff)
               OP_HALT: begin
                  halted_in = 1'b1;
                  st_in     = ST_HALT;
                  npc_in    = pc_ff;
               end
               OP_SET: begin
                  reg_we    = 1'b1;
                  reg_wdata = val_ff[1];
               end
               OP_PUSH: begin
                  if (sp_ff == SP_FULL) begin
                     st_in  = ST_STACK;
                     npc_in = pc_ff;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = val_ff[0];
                     sp_in     = sp_ff + PW'(1);
                  end
               end
               OP_POP, OP_RET: begin
                  if (sp_ff == '0) begin
                     st_in  = ST_STACK;
                     npc_in = pc_ff;
                  end else begin
                     state_in = S_STKW;
                  end
               end
               OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_AND, OP_OR, OP_NOT: begin
                  reg_we    = 1'b1;
                  reg_wdata = alu_result;
               end
               OP_JMP: npc_in = val_ff[0];
               OP_JT: begin
                  if (val_ff[0] != 16'd0) begin
                     npc_in = val_ff[1];
                  end
               end
               OP_JF: begin
                  if (val_ff[0] == 16'd0) begin
                     npc_in = val_ff[1];
                  end
               end
               OP_MOD: begin
                  if (alu_stat.zero_div) begin
                     st_in  = ST_MOD0;
                     npc_in = pc_ff;
                  end else begin
                     alu_req.start = 1'b1;
                     state_in      = S_MOD;
                  end
               end
               OP_RMEM: begin
                  if ({1'b0, val_ff[1]} >= MEM_LIMIT) begin
                     st_in  = ST_BADADDR;
                     npc_in = pc_ff;
                  end else begin
                     mem_raddr = val_ff[1][AW-1:0];
                     state_in  = S_MEMW;
                  end
               end
               OP_WMEM: begin
                  if ({1'b0, val_ff[0]} >= MEM_LIMIT) begin
                     st_in  = ST_BADADDR;
                     npc_in = pc_ff;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = val_ff[0][AW-1:0];
                     mem_wdata = val_ff[1];
                  end
               end
               OP_CALL: begin
                  if (sp_ff == SP_FULL) begin
                     st_in  = ST_STACK;
                     npc_in = pc_ff;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = pc_ff + 16'd2;
                     sp_in     = sp_ff + PW'(1);
                     npc_in    = val_ff[0];
                  end
               end
               OP_OUT: begin
                  ov_in = 1'b1;
                  oc_in = val_ff[0][7:0];
               end
               OP_IN: begin
                  reg_we    = 1'b1;
                  reg_wdata = {8'b0, inchr_ff};
                  iu_in     = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_MOD: begin
            if (!alu_stat.busy) begin
               reg_we    = 1'b1;
               reg_wdata = alu_result;
               state_in  = S_DONE;
            end
         end
         S_MEMW: begin
            reg_we    = 1'b1;
            reg_wdata = mem_rdata;
            state_in  = S_DONE;
         end
         S_STKW: begin
            sp_in = sp_dec;
            if (op_ff == OP_POP) begin
               reg_we    = 1'b1;
               reg_wdata = stk_rdata;
            end else begin
               npc_in = stk_rdata;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // The finished transaction waits here until the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_pc_in     = npc_ff;
               rsp_seen_in   = seen_ff;
               rsp_ov_in     = ov_ff;
               rsp_oc_in     = oc_ff;
               rsp_iu_in     = iu_ff;
               pc_in         = npc_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         sp_ff        <= '0;
         img_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         sp_ff        <= sp_in;
         img_ff       <= img_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_we) begin
            regs_ff[reg_wsel] <= reg_wdata;
         end
      end
      npc_ff        <= npc_in;
      op_ff         <= op_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      wrd_ff        <= wrd_in;
      val_ff        <= val_in;
      bad_ff        <= bad_in;
      st_ff         <= st_in;
      seen_ff       <= seen_in;
      ov_ff         <= ov_in;
      oc_ff         <= oc_in;
      iu_ff         <= iu_in;
      inchr_ff      <= inchr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_seen_ff   <= rsp_seen_in;
      rsp_ov_ff     <= rsp_ov_in;
      rsp_oc_ff     <= rsp_oc_in;
      rsp_iu_ff     <= rsp_iu_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.pc_after    = rsp_pc_ff;
   assign rsp_chan.opcode_seen = rsp_seen_ff;
   assign rsp_chan.out_valid   = rsp_ov_ff;
   assign rsp_chan.out_char    = rsp_oc_ff;
   assign rsp_chan.in_used     = rsp_iu_ff;

   `SVM_ASSERT(a_sp_bound, clock, reset, sp_ff <= SP_FULL, "stack pointer beyond stack depth")
   `SVM_ASSERT(a_halt_holds_pc, clock, reset, halted_ff |=> $stable(pc_ff), "pc moved after halt")
   `SVM_ASSERT_ALWAYS(a_no_req_in_clear, clock, state_ff == S_CLEAR |-> !req_chan.ready, "request taken during clear")
   `SVM_ASSERT(a_out_ok, clock, reset, rsp_valid_ff && rsp_ov_ff |-> rsp_status_ff == ST_OK, "output char on failed step")
endmodule
`default_nettype wire
